// File: design/point_dedup_renumber_macros.svh
// Assertion macros for the point deduplication block.
// Each macro expects aclk and aresetn in scope at the place of use.
`ifndef POINT_DEDUP_RENUMBER_MACROS_SVH
`define POINT_DEDUP_RENUMBER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PDR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pdr_pkg.sv
// Shared types and constants for the point deduplication block.
// No dependencies; imported by every module of the block.
package pdr_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_W        = 32;
    localparam int ID_W           = 9;
    localparam int TOL_W          = 63;
    localparam int APB_DW         = 64;
    localparam int APB_AW         = 4;
    localparam int S_TDATA_W      = 3 * COORD_W;
    localparam int M_TDATA_W      = 16;
    localparam int M_TUSER_W      = 2;
    // latency from a slot entering the distance unit to its hit leaving the unit
    localparam int DRAIN_CYCLES   = 5;
    localparam int DRN_W          = 3;

    // register word index (paddr above the byte lane bits)
    localparam logic REG_TOL = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pt_t;

    typedef struct packed {
        logic rotate;
        logic load;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// File: design/pdr_cell.sv
// One storage cell of the kept-point ring: holds a point, takes its neighbor's.
// Depends on pdr_pkg.
module pdr_cell import pdr_pkg::*; (
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  pt_t       nbr_pt,
    input  pt_t       load_pt,
    output pt_t       pt
);

    pt_t pt_reg;
    pt_t pt_next;

    always_comb begin
        pt_next = pt_reg;
        if (ctl.load) begin
            pt_next = load_pt;
        end else if (ctl.rotate) begin
            pt_next = nbr_pt;
        end
    end

    always_ff @(posedge aclk) begin
        pt_reg <= pt_next;
    end

    assign pt = pt_reg;

endmodule

// File: design/pdr_dist.sv
// Pipelined squared-distance test of the query point against one kept point.
// Four register stages plus a registered hit; depends on pdr_pkg.
module pdr_dist import pdr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             issue,
    input  pt_t              query,
    input  pt_t              stored,
    input  logic [TOL_W-1:0] tol,
    output logic             hit
);

    logic signed [COORD_W-1:0] qa [3];
    logic signed [COORD_W-1:0] ka [3];

    logic [COORD_W:0]       d_reg   [3];
    logic [COORD_W:0]       d_next  [3];
    logic [COORD_W:0]       neg     [3];
    logic [COORD_W-1:0]     mag_reg [3];
    logic [COORD_W-1:0]     mag_next[3];
    logic [2*COORD_W-1:0]   sq_reg  [3];
    logic [2*COORD_W-1:0]   sq_next [3];
    logic [2*COORD_W+1:0]   sum_reg;
    logic [2*COORD_W+1:0]   sum_next;
    logic [3:0]             valid_reg;
    logic [3:0]             valid_next;
    logic                   hit_reg;
    logic                   hit_next;

    assign qa[0] = query.x;
    assign qa[1] = query.y;
    assign qa[2] = query.z;
    assign ka[0] = stored.x;
    assign ka[1] = stored.y;
    assign ka[2] = stored.z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            d_next[a]   = {qa[a][COORD_W-1], qa[a]} - {ka[a][COORD_W-1], ka[a]};
            neg[a]      = ~d_reg[a] + {{COORD_W{1'b0}}, 1'b1};
            // magnitude of a 33-bit difference never exceeds 2^32-1
            mag_next[a] = d_reg[a][COORD_W] ? neg[a][COORD_W-1:0] : d_reg[a][COORD_W-1:0];
            sq_next[a]  = mag_reg[a] * mag_reg[a];
        end
        sum_next   = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
        valid_next = {valid_reg[2:0], issue};
        hit_next   = valid_reg[3] && (sum_reg < {3'b000, tol});
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            d_reg[a]   <= d_next[a];
            mag_reg[a] <= mag_next[a];
            sq_reg[a]  <= sq_next[a];
        end
        sum_reg <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// File: design/point_dedup_renumber.sv
// Top level of the point deduplication block: ring of point cells, one distance unit,
// control sequencer and tolerance register. Depends on pdr_pkg, pdr_cell, pdr_dist.
//
//   channel  | direction | handshake             | contents
//   ---------+-----------+-----------------------+--------------------------------------
//   s_       | in        | s_tvalid / s_tready   | point word, start_batch on s_tuser
//   m_       | out       | m_tvalid / m_tready   | point_id on m_tdata, kept/full on m_tuser
//   apb      | in        | psel/penable/pready   | tolerance_squared at byte address 0
//
// After a word is accepted, the ring rotates once to pass every kept point through the single
// distance unit, the unit then drains its pipeline, and a final step decides the word and
// stores it if kept; the next word is accepted only when all of this is done.
// Reset clears control state and sets the tolerance to 1; cell contents stay undefined.
// A finished result waits in the output register while the next word is taken in;
// that word's decision holds until the output register is free.
`include "point_dedup_renumber_macros.svh"

module point_dedup_renumber import pdr_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: coord_x [31:0], coord_y [63:32], coord_z [95:64]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: start_batch [0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: point_id [8:0], zero [15:9]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: kept [0], store_full [1]
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [DRN_W-1:0] drain_reg, drain_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;
    logic             dup_reg, dup_next;
    pt_t              q_reg, q_next;
    logic [TOL_W-1:0] tol_reg, tol_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_kept_reg, m_kept_next;
    logic             m_full_reg, m_full_next;
    logic [ID_W-1:0]  m_id_reg, m_id_next;

    logic             rotate_en;
    logic             load_en;
    logic             issue;
    logic             hit;
    logic             out_free;
    logic             apb_wr;

    cell_ctl_t        cell_ctl [MAX_POINTS];
    pt_t              cell_pt  [MAX_POINTS];

    // ---------------------------------------------------------------- point ring
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        localparam int NXT = (i + 1) % MAX_POINTS;

        assign cell_ctl[i].rotate = rotate_en;
        assign cell_ctl[i].load   = load_en && (count_reg == CNT_W'(i));

        pdr_cell u_cell (
            .aclk    (aclk),
            .ctl     (cell_ctl[i]),
            .nbr_pt  (cell_pt[NXT]),
            .load_pt (q_reg),
            .pt      (cell_pt[i])
        );
    end

    // cell 0 is the head of the ring: it feeds the distance unit
    pdr_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .query   (q_reg),
        .stored  (cell_pt[0]),
        .tol     (tol_reg),
        .hit     (hit)
    );

    // ---------------------------------------------------------------- sequencer
    assign out_free  = !m_valid_reg || m_tready;
    assign count_inc = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        drain_next   = drain_reg;
        count_next   = count_reg;
        dup_next     = dup_reg | hit;
        q_next       = q_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kept_next  = m_kept_reg;
        m_full_next  = m_full_reg;
        m_id_next    = m_id_reg;
        s_tready     = 1'b0;
        rotate_en    = 1'b0;
        load_en      = 1'b0;
        issue        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    q_next     = pt_t'(s_tdata);
                    dup_next   = 1'b0;
                    k_next     = '0;
                    state_next = ST_SCAN;
                    if (s_tuser) begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                rotate_en = 1'b1;
                issue     = CNT_W'(k_reg) < count_reg;
                if (k_reg == IDX_W'(MAX_POINTS - 1)) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + {{(IDX_W-1){1'b0}}, 1'b1};
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + {{(DRN_W-1){1'b0}}, 1'b1};
                if (drain_reg == DRN_W'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the decision until the output register can take it
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kept_next  = 1'b0;
                    m_full_next  = 1'b0;
                    m_id_next    = '0;
                    if (!dup_reg) begin
                        if (count_reg != CNT_W'(MAX_POINTS)) begin
                            load_en     = 1'b1;
                            count_next  = count_inc;
                            m_kept_next = 1'b1;
                            m_id_next   = ID_W'(count_inc);
                        end else begin
                            m_full_next = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            drain_reg   <= '0;
            count_reg   <= '0;
            dup_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            drain_reg   <= drain_next;
            count_reg   <= count_next;
            dup_reg     <= dup_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg      <= q_next;
        m_kept_reg <= m_kept_next;
        m_full_reg <= m_full_next;
        m_id_reg   <= m_id_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-ID_W){1'b0}}, m_id_reg};
    assign m_tuser  = {m_full_reg, m_kept_reg};

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_TOL);

    always_comb begin
        tol_next = tol_reg;
        if (apb_wr) begin
            tol_next = pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= {{(TOL_W-1){1'b0}}, 1'b1};
        end else begin
            tol_reg <= tol_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1] == REG_TOL) begin
            prdata = {{(APB_DW-TOL_W){1'b0}}, tol_reg};
        end
    end

    // ---------------------------------------------------------------- checks
    `PDR_ASSERT_NOW(a_drained_at_finish, state_reg == ST_FINISH, !hit, "hit after drain")
    `PDR_ASSERT_NEXT(a_accept_starts_scan, s_tvalid && s_tready,
        state_reg == ST_SCAN && k_reg == '0, "accept did not start scan at slot 0")
    `PDR_ASSERT_NEXT(a_full_matches_count, state_reg == ST_FINISH && out_free && !dup_reg,
        m_full_reg == ($past(count_reg) == CNT_W'(MAX_POINTS)), "full flag mismatch")

endmodule
